[rtl/lpmd_pkg.sv]
// Shared types and constants for the length-prefixed message deframer.
package lpmd_pkg;

  // Default header size in bytes.
  localparam int HEADER_BYTES_DEF = 10;

  // Header byte positions that carry decoded fields (sync, type, length, tail).
  localparam int FIELD_BYTES = 10;

  // Configuration register indexes.
  localparam logic CFG_SYNC_BYTE = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  // Reset value of the maximum message length register.
  localparam logic [30:0] MAX_LENGTH_RESET = 31'd65536;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_BODY    = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  // One result word as it travels from the parser to the output buffer.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  message_type;
    logic [31:0] message_length;
    logic [31:0] header_tail;
    logic [7:0]  body_byte;
    logic        last;
  } result_t;

endpackage

[rtl/lpmd_parser.sv]
// Header collection, header check and body counting for the deframer.
module lpmd_parser #(
  parameter int HEADER_BYTES = lpmd_pkg::HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [30:0]         cfg_data,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                chunk_last,
  output logic                res_valid,
  output lpmd_pkg::result_t   res
);

  localparam int CW = $clog2(HEADER_BYTES);

  // Configuration registers.
  logic [7:0]  sync_byte;
  logic [30:0] max_message_length;

  // Parser state.
  lpmd_pkg::phase_t phase, phase_next;
  logic [CW-1:0]    header_count, header_count_next;
  logic [31:0]      bytes_remaining, bytes_remaining_next;
  logic [7:0]       header_store [HEADER_BYTES];
  logic             store_we;

  // Header bytes as seen on the completing word; bytes past the header read as zero.
  logic [7:0]  hdr [lpmd_pkg::FIELD_BYTES];
  logic [31:0] len;
  logic [31:0] tail;
  logic [31:0] rem_dec;
  logic        hdr_done;
  logic        hdr_ok;

  for (genvar i = 0; i < lpmd_pkg::FIELD_BYTES; i++) begin : g_hdr
    if (i < HEADER_BYTES - 1) begin : g_stored
      assign hdr[i] = header_store[i];
    end else if (i == HEADER_BYTES - 1) begin : g_incoming
      assign hdr[i] = data_byte;
    end else begin : g_beyond
      assign hdr[i] = 8'd0;
    end
  end

  assign len  = {hdr[5], hdr[4], hdr[3], hdr[2]};
  assign tail = {hdr[9], hdr[8], hdr[7], hdr[6]};
  assign rem_dec = bytes_remaining - 32'd1;
  assign hdr_done = (header_count == CW'(HEADER_BYTES - 1));
  assign hdr_ok = (hdr[0] == sync_byte) && (len <= {1'b0, max_message_length}) &&
                  (len >= 32'(HEADER_BYTES));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= 8'd0;
      max_message_length <= lpmd_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpmd_pkg::CFG_SYNC_BYTE:  sync_byte <= cfg_data[7:0];
        lpmd_pkg::CFG_MAX_LENGTH: max_message_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lpmd_pkg::PH_HEADER;
      header_count <= '0;
      bytes_remaining <= 32'd0;
    end else if (step) begin
      phase <= phase_next;
      header_count <= header_count_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  // Header store: written at the current fill position.
  always_ff @(posedge clk) begin
    if (store_we) begin
      header_store[header_count] <= data_byte;
    end
  end

  // Next state and the result for the current word.
  always_comb begin
    phase_next = phase;
    header_count_next = header_count;
    bytes_remaining_next = bytes_remaining;
    store_we = 1'b0;
    res_valid = 1'b0;
    res = '0;
    unique case (phase)
      lpmd_pkg::PH_DISCARD: begin
        if (chunk_last) begin
          phase_next = lpmd_pkg::PH_HEADER;
          header_count_next = '0;
        end
      end
      lpmd_pkg::PH_BODY: begin
        res_valid = step;
        res.kind = lpmd_pkg::KIND_BODY;
        res.body_byte = data_byte;
        res.last = (rem_dec == 32'd0);
        bytes_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_next = lpmd_pkg::PH_HEADER;
        end
      end
      default: begin
        // Collecting header bytes; the unused phase code behaves the same.
        phase_next = lpmd_pkg::PH_HEADER;
        if (!hdr_done) begin
          store_we = step;
          header_count_next = header_count + CW'(1);
        end else begin
          header_count_next = '0;
          res_valid = step;
          res.message_type = hdr[1];
          res.message_length = len;
          res.header_tail = tail;
          if (!hdr_ok) begin
            res.kind = lpmd_pkg::KIND_ERROR;
            phase_next = chunk_last ? lpmd_pkg::PH_HEADER : lpmd_pkg::PH_DISCARD;
          end else begin
            res.kind = lpmd_pkg::KIND_HEADER;
            bytes_remaining_next = len - 32'(HEADER_BYTES);
            res.last = (len == 32'(HEADER_BYTES));
            phase_next = res.last ? lpmd_pkg::PH_HEADER : lpmd_pkg::PH_BODY;
          end
        end
      end
    endcase
  end

endmodule

[rtl/lpmd_outbuf.sv]
// Two-entry result buffer that decouples the output stall from the input side.
module lpmd_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpmd_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output lpmd_pkg::result_t head
);

  lpmd_pkg::result_t ent0, ent1;
  logic [1:0]        count;
  logic              pop;

  assign out_valid = (count != 2'd0);
  assign pop = out_valid && !out_stall;
  assign full = (count == 2'd2);
  assign head = ent0;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry data: entry 0 is always the oldest word.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        ent0 <= push_data;
      end else begin
        ent0 <= ent1;
      end
      if (push && count == 2'd2) begin
        ent1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        ent0 <= push_data;
      end else begin
        ent1 <= push_data;
      end
    end
  end

endmodule

[rtl/length_prefixed_message_deframer_top.sv]
// Top level of the length-prefixed message deframer.
//
// The deframer takes one stream byte per clock cycle while not stalled and splits
// the stream into messages of a header of HEADER_BYTES bytes followed by a body.
// Each byte is handled by one pass of compare and counter logic, and its result
// (header, body byte or header error) is in the output buffer on the next cycle.
// A two-word output buffer lets input bytes keep flowing while one result waits;
// the input stalls only when both buffer entries are occupied. Configuration
// registers should be written only while no message traffic is in flight.
module length_prefixed_message_deframer_top #(
  parameter int HEADER_BYTES = lpmd_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        chunk_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  message_type,
  output logic [31:0] message_length,
  output logic [31:0] header_tail,
  output logic [7:0]  body_byte,
  output logic        last
);

  logic              step;
  logic              res_valid;
  lpmd_pkg::result_t res;
  lpmd_pkg::result_t head;
  logic              full;

  assign in_stall = full;
  assign step = in_valid && !full;

  // Per-byte parsing.
  lpmd_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .data_byte (data_byte),
    .chunk_last(chunk_last),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result buffering toward the output channel.
  lpmd_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_data(res),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head)
  );

  assign kind = head.kind;
  assign message_type = head.message_type;
  assign message_length = head.message_length;
  assign header_tail = head.header_tail;
  assign body_byte = head.body_byte;
  assign last = head.last;

endmodule
